/* hw/rtl/sha_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, codes and constant tables for the SHA-256/224 hash engine.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int WORD_W = 32;

  // Source of the word shifted into the message schedule window
  typedef enum logic [2:0] {
    WSRC_DATA  = 3'd0,  // input word as is
    WSRC_LAST  = 3'd1,  // short last input word, masked, with the 0x80 byte
    WSRC_PAD80 = 3'd2,  // 0x80000000 after a full last word
    WSRC_ZERO  = 3'd3,  // zero fill
    WSRC_LENHI = 3'd4,  // upper half of the bit length
    WSRC_LENLO = 3'd5   // lower half of the bit length
  } wsrc_t;

  typedef struct packed {
    logic        push;       // shift one message word into the window
    wsrc_t       wsrc;
    logic        len_add;    // add the accepted word's bits to the length
    logic        load_iv;    // start of message: latch mode, load initial values
    logic        init_vars;  // copy chaining values into the working variables
    logic        round;      // run one compression round
    logic [5:0]  rnd;        // round number
    logic        add_cv;     // fold working variables into the chaining values
    logic        shift_cv;   // advance the digest word on the output
    logic        clr_len;    // message done: clear the bit length
  } sha_cmd_t;

  typedef struct packed {
    logic len_zero;
    logic active_224;
  } sha_sts_t;

  localparam logic [WORD_W-1:0] PAD_WORD = 32'h8000_0000;

  // Initial values, element 0 holds h0
  localparam logic [7:0][WORD_W-1:0] IV_256 = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [7:0][WORD_W-1:0] IV_224 = {
    32'hbefa4fa4, 32'h64f98fa7, 32'h68581511, 32'hffc00b31,
    32'hf70e5939, 32'h3070dd17, 32'h367cd507, 32'hc1059ed8
  };

  function automatic logic [WORD_W-1:0] round_k(input logic [5:0] idx);
    logic [WORD_W-1:0] k;
    unique case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

/* hw/rtl/sha_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_datapath
// Schedule window, round logic, chaining values, bit length and mode.
// ----------------------------------------------------------------------------
module sha_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  sha_pkg::sha_cmd_t  cmd,
  output sha_pkg::sha_sts_t  sts,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic [31:0]        in_data,
  input  logic [2:0]         in_count,
  input  logic               in_last,
  output logic [31:0]        digest
);

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  logic        mode_r;
  logic        active_r;
  logic [63:0] len_r;
  logic [63:0] len_nxt;
  logic [31:0] win_r [16];
  logic [31:0] cv_r  [8];
  logic [31:0] v_r   [8];

  logic [31:0] word;
  logic [31:0] sched;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [5:0]  len_amt;
  logic [31:0] mask;
  logic [31:0] pad;

  // Short last word: keep the valid bytes, place 0x80 right behind them
  always_comb begin
    unique case (in_count[1:0])
      2'd0: begin mask = 32'h0000_0000; pad = 32'h8000_0000; end
      2'd1: begin mask = 32'hff00_0000; pad = 32'h0080_0000; end
      2'd2: begin mask = 32'hffff_0000; pad = 32'h0000_8000; end
      2'd3: begin mask = 32'hffff_ff00; pad = 32'h0000_0080; end
      default: begin mask = '0; pad = '0; end
    endcase
  end

  always_comb begin
    unique case (cmd.wsrc)
      sha_pkg::WSRC_DATA:  word = in_data;
      sha_pkg::WSRC_LAST:  word = (in_data & mask) | pad;
      sha_pkg::WSRC_PAD80: word = sha_pkg::PAD_WORD;
      sha_pkg::WSRC_ZERO:  word = '0;
      sha_pkg::WSRC_LENHI: word = len_r[63:32];
      sha_pkg::WSRC_LENLO: word = len_r[31:0];
      default:             word = '0;
    endcase
  end

  // Bits added by an accepted word; counts above four act as four
  always_comb begin
    if (!in_last || in_count[2]) begin
      len_amt = 6'd32;
    end else begin
      len_amt = {1'b0, in_count[1:0], 3'b000};
    end
    len_nxt = len_r + {58'd0, len_amt};
  end

  // Next schedule word w[t+16] from the fixed taps of the window
  assign sched = win_r[0]
               + (rotr(win_r[1], 7) ^ rotr(win_r[1], 18) ^ (win_r[1] >> 3))
               + win_r[9]
               + (rotr(win_r[14], 17) ^ rotr(win_r[14], 19) ^ (win_r[14] >> 10));

  assign t1 = v_r[7]
            + (rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25))
            + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
            + sha_pkg::round_k(cmd.rnd) + win_r[0];
  assign t2 = (rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22))
            + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      active_r <= 1'b0;
      len_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (cmd.load_iv) begin
        active_r <= mode_r;
      end
      if (cmd.clr_len) begin
        len_r <= '0;
      end else if (cmd.len_add) begin
        len_r <= len_nxt;
      end
    end
  end

  // Schedule window: shift in a message word or a fresh schedule word
  always_ff @(posedge clk) begin
    if (cmd.push || cmd.round) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[15] <= cmd.push ? word : sched;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_vars) begin
      v_r <= cv_r;
    end else if (cmd.round) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_iv) begin
      for (int i = 0; i < 8; i++) begin
        cv_r[i] <= mode_r ? sha_pkg::IV_224[i] : sha_pkg::IV_256[i];
      end
    end else if (cmd.add_cv) begin
      for (int i = 0; i < 8; i++) begin
        cv_r[i] <= cv_r[i] + v_r[i];
      end
    end else if (cmd.shift_cv) begin
      for (int i = 0; i < 7; i++) begin
        cv_r[i] <= cv_r[i+1];
      end
      cv_r[7] <= cv_r[0];
    end
  end

  assign digest         = cv_r[0];
  assign sts.len_zero   = (len_r == 64'd0);
  assign sts.active_224 = active_r;

endmodule

/* hw/rtl/sha_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_ctrl
// Sequencer: word intake, padding, 64 rounds per block, digest output.
// ----------------------------------------------------------------------------
module sha_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [2:0]         in_count,
  input  logic               in_last,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic               out_tlast,
  output sha_pkg::sha_cmd_t  cmd,
  input  sha_pkg::sha_sts_t  sts
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_COMP = 3'd2;
  localparam logic [2:0] ST_FOLD = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [3:0] pos_r, pos_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic [2:0] ocnt_r, ocnt_nxt;
  logic       pad_r, pad_nxt;       // finishing a message
  logic       need80_r, need80_nxt; // full last word: 0x80 word still owed
  logic       hidone_r, hidone_nxt;
  logic       lodone_r, lodone_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tlast  = (ocnt_r == (sts.active_224 ? 3'd6 : 3'd7));
  assign in_acc     = in_tvalid && in_tready;
  assign out_acc    = out_tvalid && out_tready;

  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    rnd_nxt    = rnd_r;
    ocnt_nxt   = ocnt_r;
    pad_nxt    = pad_r;
    need80_nxt = need80_r;
    hidone_nxt = hidone_r;
    lodone_nxt = lodone_r;
    cmd        = '0;
    cmd.wsrc   = sha_pkg::WSRC_DATA;
    cmd.rnd    = rnd_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cmd.push    = 1'b1;
          cmd.len_add = 1'b1;
          cmd.load_iv = sts.len_zero && (pos_r == 4'd0);
          if (in_last) begin
            pad_nxt = 1'b1;
            if (in_count[2]) begin
              need80_nxt = 1'b1;
            end else begin
              cmd.wsrc = sha_pkg::WSRC_LAST;
            end
          end
          pos_nxt = pos_r + 4'd1;
          if (pos_r == 4'd15) begin
            cmd.init_vars = 1'b1;
            rnd_nxt       = '0;
            state_nxt     = ST_COMP;
          end else if (in_last) begin
            state_nxt = ST_PAD;
          end
        end
      end

      ST_PAD: begin
        cmd.push = 1'b1;
        if (need80_r) begin
          cmd.wsrc   = sha_pkg::WSRC_PAD80;
          need80_nxt = 1'b0;
        end else if (pos_r == 4'd14 && !hidone_r) begin
          cmd.wsrc   = sha_pkg::WSRC_LENHI;
          hidone_nxt = 1'b1;
        end else if (pos_r == 4'd15 && hidone_r) begin
          cmd.wsrc   = sha_pkg::WSRC_LENLO;
          lodone_nxt = 1'b1;
        end else begin
          cmd.wsrc = sha_pkg::WSRC_ZERO;
        end
        pos_nxt = pos_r + 4'd1;
        if (pos_r == 4'd15) begin
          cmd.init_vars = 1'b1;
          rnd_nxt       = '0;
          state_nxt     = ST_COMP;
        end
      end

      ST_COMP: begin
        cmd.round = 1'b1;
        rnd_nxt   = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = ST_FOLD;
        end
      end

      ST_FOLD: begin
        cmd.add_cv = 1'b1;
        priority if (lodone_r) begin
          ocnt_nxt  = '0;
          state_nxt = ST_OUT;
        end else if (pad_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_OUT: begin
        if (out_acc) begin
          cmd.shift_cv = 1'b1;
          ocnt_nxt     = ocnt_r + 3'd1;
          if (out_tlast) begin
            cmd.clr_len = 1'b1;
            pos_nxt     = '0;
            pad_nxt     = 1'b0;
            need80_nxt  = 1'b0;
            hidone_nxt  = 1'b0;
            lodone_nxt  = 1'b0;
            state_nxt   = ST_IDLE;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pos_r    <= '0;
      rnd_r    <= '0;
      ocnt_r   <= '0;
      pad_r    <= 1'b0;
      need80_r <= 1'b0;
      hidone_r <= 1'b0;
      lodone_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pos_r    <= pos_nxt;
      rnd_r    <= rnd_nxt;
      ocnt_r   <= ocnt_nxt;
      pad_r    <= pad_nxt;
      need80_r <= need80_nxt;
      hidone_r <= hidone_nxt;
      lodone_r <= lodone_nxt;
    end
  end

endmodule

/* hw/rtl/sha256_224_hash_engine.sv */
`timescale 1ns / 1ps
// Sequence: message words are taken while the engine is idle; every 16th word starts 64
//   rounds plus one fold, during which input waits. The last word adds padding, one word
//   per cycle over the rest of its block and at most one extra block, then eight (SHA-224:
//   seven) digest words, one per cycle while out_tready is high.
// Throughput: one message at a time; input waits from the last word to the final digest.
// Reset: synchronous active-low rst_n clears the sequencer, bit length and mode.
// ----------------------------------------------------------------------------
// sha256_224_hash_engine
// Streaming SHA-256 / SHA-224 engine: controller plus round datapath.
// ----------------------------------------------------------------------------
module sha256_224_hash_engine (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: bit 0 = mode_224
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  // Message words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] data_word
  input  logic [2:0]  in_tuser,   // [2:0] byte_count
  input  logic        in_tlast,   // last_word
  // Digest words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic        out_tlast   // digest_last
);

  sha_pkg::sha_cmd_t cmd;
  sha_pkg::sha_sts_t sts;

  // Sequencer: owns word position, round count and padding progress
  sha_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_count   (in_tuser),
    .in_last    (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

  // Datapath: window, round unit, chaining values; digest comes from h0 slot
  sha_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_tdata),
    .in_count    (in_tuser),
    .in_last     (in_tlast),
    .digest      (out_tdata)
  );

endmodule

/* hw/rtl/sha_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_checker
// Port-level checks of the hash engine, bound to the top level.
// ----------------------------------------------------------------------------
module sha_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);

  // Hold a stalled digest word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("digest word changed while stalled");

  // Never take message words while a digest is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready during digest output");

  // Last message word closes the input until the digest is out
  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input ready right after last word");

  // Final digest word ends the output burst
  a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid)
    else $error("output continues after final digest word");

endmodule

bind sha256_224_hash_engine sha_checker u_sha_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
